@@ rtl/core/bdq_pkg.sv @@
// Package with the constants, request codes and cell control types of the deque.
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int OUT_W      = 40;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_POP_BACK   = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_DELETE     = 3'd4
	} req_e_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_DEL,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     in_range;
		logic     load_here;
	} cell_ctl_t;

endpackage

@@ rtl/core/bdq_cell.sv @@
// One storage cell of the deque: holds a word, shifts with its neighbors, matches for delete.
module bdq_cell
	import bdq_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	input  logic                  seen_in,
	output logic                  seen_out,
	output logic [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;
	logic                  match;

	assign match    = ctl.in_range && (word_q == key);
	assign seen_out = seen_in || match;
	assign word     = word_q;

	// A delete closes the gap: the matching cell and all cells behind it take their right neighbor.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_SHR:  word_q <= left_word;
			CELL_SHL:  word_q <= right_word;
			CELL_DEL: begin
				if (seen_out) word_q <= right_word;
			end
			CELL_LOAD: begin
				if (ctl.load_here) word_q <= key;
			end
			default:   word_q <= word_q;
		endcase
	end

endmodule

@@ rtl/core/bounded_deque_with_delete_unit.sv @@
// Top level of the bounded deque with delete: request decode, cell row, count and result register.
// The result of a request is captured in the result register at the clock edge that accepts it.
// Throughput: one request per cycle while results are taken; the result register frees itself when the result is taken.
// The first-match search runs combinationally as a priority chain through the row of cells.
// Reset clears the entry count and the result valid flag; stored words stay undefined until written.
module bounded_deque_with_delete_unit
	import bdq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // [31:0] value
	input  logic [2:0]       s_tuser,  // [2:0] req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	// [31:0] read_value, [32] was_empty, [33] was_full, [34] found, [39:35] entry_count
	output logic [OUT_W-1:0] m_tdata
);

	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_next;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [DATA_WIDTH-1:0] key;
	cell_op_t              op;
	logic [IDX_W-1:0]      last_idx;
	logic [DATA_WIDTH-1:0] words [DEPTH];
	logic [DEPTH:0]        seen;
	logic                  found;
	logic [31:0]           read_value;
	logic                  was_empty;
	logic                  was_full;
	req_e_t                req;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign req      = req_e_t'(s_tuser);
	assign key      = DATA_WIDTH'(s_tdata);
	assign full     = (count_q == COUNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign last_idx = IDX_W'(count_q - 1'b1);
	assign seen[0]  = 1'b0;
	assign found    = seen[DEPTH];

	always_comb begin
		op = CELL_HOLD;
		if (accept) begin
			unique case (req)
				REQ_PUSH_BACK:  op = full  ? CELL_HOLD : CELL_LOAD;
				REQ_PUSH_FRONT: op = full  ? CELL_HOLD : CELL_SHR;
				REQ_POP_FRONT:  op = empty ? CELL_HOLD : CELL_SHL;
				REQ_DELETE:     op = CELL_DEL;
				default:        op = CELL_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t             ctl;
		logic [DATA_WIDTH-1:0] left_word;
		logic [DATA_WIDTH-1:0] right_word;

		assign ctl.op        = op;
		assign ctl.in_range  = (COUNT_W'(i) < count_q);
		assign ctl.load_here = (COUNT_W'(i) == count_q);

		if (i == 0) begin : g_first
			assign left_word = key;
		end else begin : g_mid_l
			assign left_word = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_word = words[i];
		end else begin : g_mid_r
			assign right_word = words[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (key),
			.left_word  (left_word),
			.right_word (right_word),
			.seen_in    (seen[i]),
			.seen_out   (seen[i+1]),
			.word       (words[i])
		);
	end

	always_comb begin
		read_value = 32'd0;
		was_empty  = 1'b0;
		was_full   = 1'b0;
		count_next = count_q;
		unique case (req)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (full) was_full = 1'b1;
				else count_next = count_q + 1'b1;
			end
			REQ_POP_BACK: begin
				if (empty) begin
					was_empty  = 1'b1;
					read_value = '1;
				end else begin
					read_value = 32'($signed(words[last_idx]));
					count_next = count_q - 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					was_empty  = 1'b1;
					read_value = '1;
				end else begin
					read_value = 32'($signed(words[0]));
					count_next = count_q - 1'b1;
				end
			end
			REQ_DELETE: begin
				if (found) count_next = count_q - 1'b1;
			end
			default: count_next = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (accept) begin
				m_valid_q <= 1'b1;
				count_q   <= count_next;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {5'(count_next), (req == REQ_DELETE) && found, was_full, was_empty,
				read_value};
		end
	end

endmodule

@@ verif/tb_bounded_deque_with_delete_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bounded deque with delete, using a queue-based predictor.
module tb_bounded_deque_with_delete_unit
	import bdq_pkg::*;
;

	// Request codes with no operation behind them; the block must ignore them.
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_REQUESTS = 1050;
	localparam int RX_HOLD_CYCLES = 64;

	// Laid out to match m_tdata, lowest field last.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               found;
		logic               full;
		logic               empty;
		logic [31:0]        rd;
	} deque_res_t;

	typedef struct packed {
		logic [2:0]  req;
		logic [31:0] val;
		bit          typed;
		deque_res_t  want;
	} plan_row_t;

	localparam plan_row_t PLAN [26] = '{
		'{REQ_POP_BACK,   32'h0,        1'b1, '{5'd0,  1'b0, 1'b0, 1'b1, 32'hFFFFFFFF}},
		'{REQ_POP_FRONT,  32'h0,        1'b1, '{5'd0,  1'b0, 1'b0, 1'b1, 32'hFFFFFFFF}},
		'{REQ_DELETE,     32'h0,        1'b1, '{5'd0,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_SPARE_LO,   32'h0,        1'b1, '{5'd0,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_PUSH_BACK,  32'h7FFFFFFF, 1'b1, '{5'd1,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_PUSH_FRONT, 32'h80000000, 1'b1, '{5'd2,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_PUSH_BACK,  32'hFFFFFFFF, 1'b1, '{5'd3,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_PUSH_FRONT, 32'h0,        1'b1, '{5'd4,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_POP_BACK,   32'h0,        1'b1, '{5'd3,  1'b0, 1'b0, 1'b0, 32'hFFFFFFFF}},
		'{REQ_PUSH_BACK,  32'h80000000, 1'b1, '{5'd4,  1'b0, 1'b0, 1'b0, 32'h0}},
		'{REQ_PUSH_BACK,  32'h55555555, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'hAAAAAAAA, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h00000001, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h00000002, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h12345678, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'hFEDCBA98, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h00000003, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h7FFFFFFE, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h80000001, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h0F0F0F0F, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'hF0F0F0F0, 1'b0, '0},
		'{REQ_PUSH_FRONT, 32'h00000004, 1'b0, '0},
		'{REQ_PUSH_BACK,  32'h00000005, 1'b1, '{5'd16, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{REQ_PUSH_FRONT, 32'h00000006, 1'b1, '{5'd16, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{REQ_DELETE,     32'h80000000, 1'b1, '{5'd15, 1'b1, 1'b0, 1'b0, 32'h0}},
		'{REQ_SPARE_HI,   32'hFFFFFFFF, 1'b1, '{5'd15, 1'b0, 1'b0, 1'b0, 32'h0}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;  // [31:0] value
	logic [2:0]        s_tuser = '0;  // [2:0] req_type
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// [31:0] read_value, [32] was_empty, [33] was_full, [34] found, [39:35] entry_count
	logic [OUT_W-1:0]  m_tdata;

	logic [DATA_WIDTH-1:0] shadow_deque[$];
	deque_res_t            pending_results[$];
	int                    mismatch_count = 0;
	bit                    calm = 1'b0;
	bit                    rx_hold = 1'b0;

	bounded_deque_with_delete_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// Applies one request to the shadow deque and returns the result it should give.
	function automatic deque_res_t deque_apply(logic [2:0] req, logic [31:0] val);
		deque_res_t r;
		logic [DATA_WIDTH-1:0] w;
		int hit_at;
		r = '0;
		w = val[DATA_WIDTH-1:0];
		hit_at = -1;
		case (req)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (shadow_deque.size() >= DEPTH)
					r.full = 1'b1;
				else if (req == REQ_PUSH_BACK)
					shadow_deque.push_back(w);
				else
					shadow_deque.push_front(w);
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				if (shadow_deque.size() == 0) begin
					r.empty = 1'b1;
					r.rd = '1;
				end else if (req == REQ_POP_BACK) begin
					r.rd = 32'($signed(shadow_deque.pop_back()));
				end else begin
					r.rd = 32'($signed(shadow_deque.pop_front()));
				end
			end
			REQ_DELETE: begin
				for (int i = 0; i < shadow_deque.size() && hit_at < 0; i++)
					if (shadow_deque[i] == w)
						hit_at = i;
				if (hit_at >= 0) begin
					shadow_deque.delete(hit_at);
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_deque.size());
		return r;
	endfunction

	// Holds the request on the bus until it is taken, then records what it should produce.
	task automatic offer(input logic [2:0] req, input logic [31:0] val, input bit typed,
			input deque_res_t want);
		deque_res_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		predicted = deque_apply(req, val);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Small values come up often so that duplicates exist for the delete search.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'hFFFFFFFF;
			3, 4, 5: return 32'($urandom_range(0, 7));
			default: return 32'($urandom);
		endcase
	endfunction

	initial begin
		int idx;
		int real_items;
		int roll;
		bit filling;
		logic [2:0] req;
		logic [31:0] val;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i])
			offer(PLAN[i].req, PLAN[i].val, PLAN[i].typed, PLAN[i].want);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);

		idx = 0;
		real_items = 0;
		while (real_items < RANDOM_REQUESTS) begin
			calm = (real_items >= 400 && real_items < 600);
			if (idx == 250)
				rx_hold = 1'b1;
			if (idx == 800) begin
				// Let the block drain completely before going on.
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < 13) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end

			// Alternate between filling and draining so both ends are reached often.
			filling = ((idx / 80) % 2) == 0;
			roll = $urandom_range(0, 99);
			if (roll >= 96)
				req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			else if (roll >= 80)
				req = REQ_DELETE;
			else if (filling)
				req = roll < 30 ? REQ_PUSH_BACK : roll < 60 ? REQ_PUSH_FRONT :
					roll < 70 ? REQ_POP_BACK : REQ_POP_FRONT;
			else
				req = roll < 12 ? REQ_PUSH_BACK : roll < 24 ? REQ_PUSH_FRONT :
					roll < 52 ? REQ_POP_BACK : REQ_POP_FRONT;

			if (req == REQ_DELETE && shadow_deque.size() != 0 && $urandom_range(0, 9) < 7)
				val = 32'($signed(shadow_deque[$urandom_range(0, shadow_deque.size() - 1)]));
			else
				val = pick_value();

			offer(req, val, 1'b0, '0);
			idx++;
			if (req <= REQ_DELETE)
				real_items++;
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				// A long hold-off lets the result register back up into the input.
				rx_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || $urandom_range(0, 99) >= 13;
		end
	end

	always @(posedge clk) begin : result_check
		deque_res_t got;
		deque_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = deque_res_t'(m_tdata);
			if (pending_results.size() == 0) begin
				$error("result %h arrived with no request outstanding", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.rd !== want.rd) begin
					$error("read_value: expected %h, got %h", want.rd, got.rd);
					mismatch_count++;
				end
				if (got.empty !== want.empty) begin
					$error("was_empty: expected %b, got %b", want.empty, got.empty);
					mismatch_count++;
				end
				if (got.full !== want.full) begin
					$error("was_full: expected %b, got %b", want.full, got.full);
					mismatch_count++;
				end
				if (got.found !== want.found) begin
					$error("found: expected %b, got %b", want.found, got.found);
					mismatch_count++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, got.count);
					mismatch_count++;
				end
			end
		end
	end

endmodule

@@ bounded_deque_with_delete_unit.f @@
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_with_delete_unit.sv
verif/tb_bounded_deque_with_delete_unit.sv
